[sv/xsr_pkg.sv]
// Package for the xoshiro256** generator with splitmix64 seeding.
// Holds the command codes, mixing constants and sequencer state type.
// No dependencies; imported by xoshiro256ss_splitmix_rng.
package xsr_pkg;

  localparam int unsigned WORD_W = 64;

  // Command codes of the input item.
  localparam logic [1:0] CMD_SEED  = 2'd0;
  localparam logic [1:0] CMD_RAW   = 2'd1;
  localparam logic [1:0] CMD_BOUND = 2'd2;

  // Splitmix64 constants and the default seed.
  localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 64'h1234_5678_9ABC_DEF0;

  // Multiply partial-product steps of the shared 32x32 unit.
  localparam logic [1:0] MSTEP_LL = 2'd0;
  localparam logic [1:0] MSTEP_LH = 2'd1;
  localparam logic [1:0] MSTEP_HL = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_ADD,
    ST_MUL,
    ST_MIX,
    ST_DRAW,
    ST_MUL9,
    ST_DIV,
    ST_OUT
  } xsr_state_t;

endpackage

[sv/xoshiro256ss_splitmix_rng.sv]
// Top level of the xoshiro256** generator with splitmix64 seeding.
// Uses xsr_pkg for command codes, constants and the sequencer state type.
// A seed item expands four state words: each needs two 64-bit multiplies,
// done as three partial products on one shared 32x32 multiplier, plus an
// add step and a mix step after each multiply. After reset the block runs
// the same sequence on the default seed and holds in_ready low until it
// ends. A raw draw passes through accept, state update, times-nine and
// hand-off. A bounded draw with a nonzero modulus adds a restoring divider
// that takes one bit per cycle. The result sits in an output register, so
// the next item is taken while a result waits; a finished draw waits for
// that register to be free.
module xoshiro256ss_splitmix_rng
  import xsr_pkg::*;
#(
  parameter int unsigned MODULUS_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_seed_value,
  input  logic [15:0] in_modulus,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_random_value
);

  // Effective divisor width: the field is 16 bits, masked to MODULUS_WIDTH.
  localparam int unsigned DIV_W = (MODULUS_WIDTH < 16) ? MODULUS_WIDTH : 16;

  xsr_state_t state_r, state_nxt;

  logic [WORD_W-1:0] st_r [4];
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] mop_r;
  logic [WORD_W-1:0] macc_r;
  logic [WORD_W-1:0] res_r;
  logic [1:0]        mstep_r;
  logic              mph_r;
  logic [1:0]        widx_r;
  logic              bounded_r;
  logic [DIV_W-1:0]  div_r;
  logic [DIV_W-1:0]  rem_r;
  logic [5:0]        dcnt_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_random_value_r;

  logic              accept;
  logic              out_free;

  // Datapath intermediate values.
  logic [WORD_W-1:0] acc_add;
  logic [WORD_W-1:0] mul_k;
  logic [31:0]       mul_x;
  logic [31:0]       mul_y;
  logic [WORD_W-1:0] mul_p;
  logic [WORD_W-1:0] times5;
  logic [WORD_W-1:0] times9;
  logic [WORD_W-1:0] n2, n3, n1, n0;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_sub;
  logic [DIV_W-1:0]  rem_next;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_random_value = out_random_value_r;

  // Shared 32x32 multiplier and its operand selection.
  assign mul_k = mph_r ? MIX_MUL_B : MIX_MUL_A;
  assign mul_x = (mstep_r == MSTEP_HL) ? mop_r[63:32] : mop_r[31:0];
  assign mul_y = (mstep_r == MSTEP_LH) ? mul_k[63:32] : mul_k[31:0];
  assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

  assign acc_add = acc_r + GOLDEN_GAMMA;

  // Scrambler output and state update of one draw.
  assign times5 = st_r[1] + {st_r[1][61:0], 2'b00};
  assign times9 = res_r + {res_r[60:0], 3'b000};
  assign n2 = st_r[2] ^ st_r[0];
  assign n3 = st_r[3] ^ st_r[1];
  assign n1 = st_r[1] ^ n2;
  assign n0 = st_r[0] ^ n3;

  // One restoring division step; remainder stays below the divisor.
  assign rem_sh  = {rem_r, res_r[63]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign rem_next = (rem_sh >= {1'b0, div_r}) ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];

  // Handshake outputs of the sequencer.
  always_comb begin
    in_ready = (state_r == ST_IDLE);
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_command == CMD_SEED) begin
            state_nxt = ST_SEED_ADD;
          end else if (in_command == CMD_RAW || in_command == CMD_BOUND) begin
            state_nxt = ST_DRAW;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SEED_ADD: state_nxt = ST_MUL;
      ST_MUL: begin
        if (mstep_r == MSTEP_HL) begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        if (!mph_r) begin
          state_nxt = ST_MUL;
        end else if (widx_r == 2'd3) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SEED_ADD;
        end
      end
      ST_DRAW: state_nxt = ST_MUL9;
      ST_MUL9: begin
        if (bounded_r && (div_r != '0)) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (dcnt_r == 6'd63) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer state; reset starts the default-seed expansion.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SEED_ADD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_random_value_r <= res_r;
    end
  end

  // Datapath registers driven by the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= DEFAULT_SEED;
      widx_r <= 2'd0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            acc_r     <= (in_seed_value != '0) ? in_seed_value : DEFAULT_SEED;
            widx_r    <= 2'd0;
            bounded_r <= (in_command == CMD_BOUND);
            div_r     <= in_modulus[DIV_W-1:0];
          end
        end
        ST_SEED_ADD: begin
          acc_r   <= acc_add;
          mop_r   <= acc_add ^ {30'd0, acc_add[63:30]};
          mph_r   <= 1'b0;
          mstep_r <= MSTEP_LL;
        end
        ST_MUL: begin
          // Low 64 bits of the product from three partial products.
          if (mstep_r == MSTEP_LL) begin
            macc_r <= mul_p;
          end else begin
            macc_r[63:32] <= macc_r[63:32] + mul_p[31:0];
          end
          mstep_r <= mstep_r + 2'd1;
        end
        ST_MIX: begin
          if (!mph_r) begin
            mop_r   <= macc_r ^ {27'd0, macc_r[63:27]};
            mph_r   <= 1'b1;
            mstep_r <= MSTEP_LL;
          end else begin
            st_r[widx_r] <= macc_r ^ {31'd0, macc_r[63:31]};
            widx_r       <= widx_r + 2'd1;
          end
        end
        ST_DRAW: begin
          res_r   <= {times5[56:0], times5[63:57]};
          st_r[0] <= n0;
          st_r[1] <= n1;
          st_r[2] <= n2 ^ {st_r[1][46:0], 17'd0};
          st_r[3] <= {n3[18:0], n3[63:19]};
        end
        ST_MUL9: begin
          res_r  <= (bounded_r && (div_r == '0)) ? '0 : times9;
          rem_r  <= '0;
          dcnt_r <= 6'd0;
        end
        ST_DIV: begin
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd63) begin
            res_r <= {{(WORD_W-DIV_W){1'b0}}, rem_next};
          end else begin
            res_r <= {res_r[62:0], 1'b0};
            rem_r <= rem_next;
          end
        end
        ST_OUT: begin
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The block is busy right after reset while it expands the default seed.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  // A draw item keeps the block busy in the following cycle.
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == CMD_RAW || in_command == CMD_BOUND)) |=> !in_ready)
    else $error("draw item did not make the block busy");

  // A bounded result with a nonzero modulus lies below the modulus.
  a_bound_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free && bounded_r && (div_r != '0))
      |=> (out_random_value < {{(WORD_W-DIV_W){1'b0}}, div_r}))
    else $error("bounded result not below modulus");

  // The multiply step counter never passes its last partial product.
  a_mstep_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (mstep_r != 2'd3))
    else $error("multiply step out of range");
`endif

endmodule
